// ===== design/pdsr_pkg.sv =====
`default_nettype none
package pdsr_pkg;

   // Field widths.
   localparam int PRESSURE_W = 14;
   localparam int ERROR_W    = 15;
   localparam int SPEED_W    = 12;
   localparam int MOTOR_W    = 13;
   localparam int PERIOD_W   = 20;
   localparam int SETTLE_W   = 5;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 14;

   localparam logic [CSR_INDEX_W-1:0] REG_TARGET    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TOLERANCE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CUTOFF    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_SPEED = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_SPEED = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ENABLE    = 3'd5;

   // Register reset values.
   localparam logic [PRESSURE_W-1:0] TARGET_RESET    = 14'd1638;
   localparam logic [PRESSURE_W-1:0] TOLERANCE_RESET = 14'd10;
   localparam logic [PRESSURE_W-1:0] CUTOFF_RESET    = 14'd200;
   localparam logic [SPEED_W-1:0]    MIN_SPEED_RESET = 12'd350;
   localparam logic [SPEED_W-1:0]    MAX_SPEED_RESET = 12'd2000;

   // Regulator state.
   localparam logic [SETTLE_W-1:0] SETTLE_SAMPLES = 5'd20;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 20'd1000;
   localparam logic [PERIOD_W-1:0] PERIOD_NUM     = 20'd1000000;

   // Shared divider: 26-bit dividend (14 x 12 bit product), 14-bit divisor.
   localparam int DIV_NUM_W = PRESSURE_W + SPEED_W;
   localparam int DIV_DEN_W = PRESSURE_W;
   localparam int DIV_CNT_W = 5;
   localparam int PERIOD_ALIGN = DIV_NUM_W - PERIOD_W;

   localparam logic [DIV_CNT_W-1:0] INTERP_ITERS = DIV_CNT_W'(DIV_NUM_W);
   localparam logic [DIV_CNT_W-1:0] PERIOD_ITERS = DIV_CNT_W'(PERIOD_W);

   typedef struct packed {
      logic [PRESSURE_W-1:0] target;
      logic [PRESSURE_W-1:0] tolerance;
      logic [PRESSURE_W-1:0] cutoff;
      logic [SPEED_W-1:0]    min_speed;
      logic [SPEED_W-1:0]    max_speed;
      logic                  enable;
      logic                  target_wr;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_EVAL = 7'b0000010,
      S_MUL  = 7'b0000100,
      S_DIV1 = 7'b0001000,
      S_ADD  = 7'b0010000,
      S_DIV2 = 7'b0100000,
      S_DONE = 7'b1000000
   } seq_state_type;

endpackage
`default_nettype wire

// ===== design/pdsr_csr.sv =====
`default_nettype none
module pdsr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pdsr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pdsr_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output pdsr_pkg::cfg_type                    cfg
);
   import pdsr_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;

   always_comb begin
      cfg_in           = cfg_ff;
      cfg_in.target_wr = 1'b0;
      if (wr) begin
         case (csr_index)
            REG_TARGET: begin
               cfg_in.target    = csr_wdata[PRESSURE_W-1:0];
               cfg_in.target_wr = 1'b1;
            end
            REG_TOLERANCE: cfg_in.tolerance = csr_wdata[PRESSURE_W-1:0];
            REG_CUTOFF:    cfg_in.cutoff    = csr_wdata[PRESSURE_W-1:0];
            REG_MIN_SPEED: cfg_in.min_speed = csr_wdata[SPEED_W-1:0];
            REG_MAX_SPEED: cfg_in.max_speed = csr_wdata[SPEED_W-1:0];
            REG_ENABLE:    cfg_in.enable    = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target    <= TARGET_RESET;
         cfg_ff.tolerance <= TOLERANCE_RESET;
         cfg_ff.cutoff    <= CUTOFF_RESET;
         cfg_ff.min_speed <= MIN_SPEED_RESET;
         cfg_ff.max_speed <= MAX_SPEED_RESET;
         cfg_ff.enable    <= 1'b0;
         cfg_ff.target_wr <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== design/pdsr_div.sv =====
`default_nettype none
module pdsr_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [pdsr_pkg::DIV_NUM_W-1:0]     dividend,
   input  logic [pdsr_pkg::DIV_DEN_W-1:0]     divisor,
   input  logic [pdsr_pkg::DIV_CNT_W-1:0]     iterations,
   output logic [pdsr_pkg::DIV_NUM_W-1:0]     quotient,
   output pdsr_pkg::div_status_type           status
);
   import pdsr_pkg::*;

   // Restoring divider, one quotient bit per cycle. The dividend shifts out
   // of the top of quo_ff while quotient bits shift in at the bottom, so a
   // left-aligned dividend run for fewer iterations yields a short quotient.
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   rem_shift, rem_diff;
   logic                 fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIV_NUM_W-1]};
      rem_diff  = rem_shift - {1'b0, den_ff};
      fits      = rem_shift >= {1'b0, den_ff};
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = iterations;
      end else if (cnt_ff != '0) begin
         if (fits) begin
            rem_in = rem_diff[DIV_DEN_W-1:0];
         end else begin
            rem_in = rem_shift[DIV_DEN_W-1:0];
         end
         quo_in  = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;

endmodule
`default_nettype wire

// ===== design/pressure_deadband_speed_regulator_top.sv =====
// A sample in the hold band goes from evaluate through add to done; at maximum
// speed the step-period division runs after add, and in the proportional region
// the interpolation division also runs before add; both use the shared restoring
// divider. No new sample is taken until the current one leaves done; a held
// or disabled sample is taken in the idle state and dropped. Reset (synchronous,
// active high) restores the sequencer, regulator and result-valid state at once.
`default_nettype none
module pressure_deadband_speed_regulator_top (
   input  logic                                    clock,
   input  logic                                    reset,
   // Sample channel.
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [pdsr_pkg::PRESSURE_W-1:0]         req_pressure,
   input  logic                                    req_hold,
   // Result channel.
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [pdsr_pkg::MOTOR_W-1:0]     rsp_motor_speed,
   output logic [pdsr_pkg::PERIOD_W-1:0]           rsp_step_period_us,
   output logic                                    rsp_target_reached,
   output logic signed [pdsr_pkg::ERROR_W-1:0]     rsp_pressure_error,
   // Configuration write channel.
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [pdsr_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [pdsr_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import pdsr_pkg::*;

   cfg_type        cfg;
   div_status_type div_stat;

   // Sequencer and per-sample working registers.
   seq_state_type              state_ff, state_in;
   logic signed [ERROR_W-1:0]  err_ff, err_in;
   logic [PRESSURE_W-1:0]      mag_ff, mag_in;
   logic                       neg_ff, neg_in;
   logic [SPEED_W-1:0]         speed_ff, speed_in;
   logic                       psign_ff, psign_in;

   // Regulator state that persists across samples.
   logic                       reached_ff, reached_in;
   logic [SETTLE_W-1:0]        settle_ff, settle_in;
   logic [PERIOD_W-1:0]        period_ff, period_in;

   // Result register.
   logic                       out_valid_ff, out_valid_in;
   logic signed [MOTOR_W-1:0]  out_speed_ff, out_speed_in;
   logic [PERIOD_W-1:0]        out_period_ff, out_period_in;
   logic                       out_reached_ff, out_reached_in;
   logic signed [ERROR_W-1:0]  out_err_ff, out_err_in;

   // Divider hookup.
   logic                       div_start;
   logic [DIV_NUM_W-1:0]       div_dividend;
   logic [DIV_DEN_W-1:0]       div_divisor;
   logic [DIV_CNT_W-1:0]       div_iters;
   logic [DIV_NUM_W-1:0]       div_quo;

   // Combinational helpers.
   logic                       accept;
   logic [ERROR_W-1:0]         mag_wide;
   logic [PRESSURE_W-1:0]      mag_now;
   logic signed [MOTOR_W-1:0]  speed_diff;
   logic [SPEED_W-1:0]         diff_mag;
   logic [DIV_NUM_W-1:0]       product;
   logic signed [MOTOR_W-1:0]  quo_signed;
   logic signed [MOTOR_W-1:0]  interp_sum;
   logic [SETTLE_W-1:0]        settle_next;
   logic                       out_free;

   pdsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pdsr_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend   (div_dividend),
      .divisor    (div_divisor),
      .iterations (div_iters),
      .quotient   (div_quo),
      .status     (div_stat)
   );

   // The block takes a new sample only from the idle state; everything else
   // is one sample working its way through the shared divider.
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign out_free  = ~out_valid_ff | ~rsp_stall;

   // Error magnitude fits in 14 bits because both operands are 14-bit unsigned.
   assign mag_wide    = err_ff[ERROR_W-1] ? ERROR_W'(-err_ff) : ERROR_W'(err_ff);
   assign mag_now     = mag_wide[PRESSURE_W-1:0];
   assign settle_next = settle_ff + 1'b1;

   // Proportional term: |error| * |max - min|, with the sign tracked apart so
   // the divider only sees magnitudes and truncation goes toward zero.
   assign speed_diff = $signed({1'b0, cfg.max_speed}) - $signed({1'b0, cfg.min_speed});
   assign diff_mag   = speed_diff[MOTOR_W-1] ? SPEED_W'(-speed_diff) : SPEED_W'(speed_diff);
   assign product    = DIV_NUM_W'(mag_ff) * DIV_NUM_W'(diff_mag);

   // The quotient never exceeds |max - min|, so its low 12 bits carry it all.
   assign quo_signed = psign_ff ? -$signed({1'b0, div_quo[SPEED_W-1:0]})
                                :  $signed({1'b0, div_quo[SPEED_W-1:0]});
   assign interp_sum = $signed({1'b0, cfg.min_speed}) + quo_signed;

   // The divider is shared: first the interpolation over the cutoff, then
   // the step period as 1000000 over the speed magnitude, left-aligned.
   always_comb begin
      div_start    = 1'b0;
      div_dividend = product;
      div_divisor  = cfg.cutoff;
      div_iters    = INTERP_ITERS;
      if (state_ff == S_MUL) begin
         div_start = 1'b1;
      end else if (state_ff == S_ADD) begin
         div_start    = (speed_ff != '0);
         div_dividend = {PERIOD_NUM, {PERIOD_ALIGN{1'b0}}};
         div_divisor  = DIV_DEN_W'(speed_ff);
         div_iters    = PERIOD_ITERS;
      end
   end

   always_comb begin
      state_in       = state_ff;
      err_in         = err_ff;
      mag_in         = mag_ff;
      neg_in         = neg_ff;
      speed_in       = speed_ff;
      psign_in       = psign_ff;
      reached_in     = reached_ff;
      settle_in      = settle_ff;
      period_in      = period_ff;
      out_valid_in   = out_valid_ff & rsp_stall;
      out_speed_in   = out_speed_ff;
      out_period_in  = out_period_ff;
      out_reached_in = out_reached_ff;
      out_err_in     = out_err_ff;

      case (state_ff)
         S_IDLE: begin
            // A held sample, or any sample while disabled, leaves no trace.
            if (accept && !req_hold && cfg.enable) begin
               err_in   = $signed({1'b0, req_pressure}) - $signed({1'b0, cfg.target});
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            mag_in   = mag_now;
            neg_in   = ~err_ff[ERROR_W-1];
            state_in = S_ADD;
            if (mag_now <= PRESSURE_W'(1) && !reached_ff) begin
               // Settling: count consecutive samples inside plus or minus one.
               speed_in = '0;
               if (settle_next >= SETTLE_SAMPLES) begin
                  reached_in = 1'b1;
                  settle_in  = '0;
               end else begin
                  settle_in = settle_next;
               end
            end else if (reached_ff && mag_now <= cfg.tolerance) begin
               speed_in = '0;
            end else begin
               reached_in = 1'b0;
               settle_in  = '0;
               // With a zero cutoff the interpolation degenerates to max speed.
               if (mag_now > cfg.cutoff || cfg.cutoff == '0) begin
                  speed_in = cfg.max_speed;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            psign_in = speed_diff[MOTOR_W-1];
            state_in = S_DIV1;
         end
         S_DIV1: begin
            if (div_stat.done) begin
               speed_in = interp_sum[SPEED_W-1:0];
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            // A zero speed keeps the previous step period.
            if (speed_ff != '0) begin
               state_in = S_DIV2;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV2: begin
            if (div_stat.done) begin
               period_in = div_quo[PERIOD_W-1:0];
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_speed_in   = neg_ff ? -$signed({1'b0, speed_ff})
                                       :  $signed({1'b0, speed_ff});
               out_period_in  = period_ff;
               out_reached_in = reached_ff;
               out_err_in     = err_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Rewriting the target restarts the settle detection.
      if (cfg.target_wr) begin
         reached_in = 1'b0;
         settle_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         reached_ff   <= 1'b1;
         settle_ff    <= '0;
         period_ff    <= PERIOD_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reached_ff   <= reached_in;
         settle_ff    <= settle_in;
         period_ff    <= period_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff         <= err_in;
      mag_ff         <= mag_in;
      neg_ff         <= neg_in;
      speed_ff       <= speed_in;
      psign_ff       <= psign_in;
      out_speed_ff   <= out_speed_in;
      out_period_ff  <= out_period_in;
      out_reached_ff <= out_reached_in;
      out_err_ff     <= out_err_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_motor_speed    = out_speed_ff;
   assign rsp_step_period_us = out_period_ff;
   assign rsp_target_reached = out_reached_ff;
   assign rsp_pressure_error = out_err_ff;

   // A new result is only ever loaded from the final sequencer state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_DONE))
      else $error("result appeared outside the final state");

   // Any motion means the target is not considered reached.
   a_motion_not_reached: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_motor_speed != '0) |-> !rsp_target_reached)
      else $error("nonzero speed reported with target reached");

   // The shared divider only runs during the two division phases.
   a_div_phase: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == S_DIV1 || state_ff == S_DIV2))
      else $error("divider busy outside a division phase");

   // The step period can never collapse to zero.
   a_period_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_step_period_us != '0))
      else $error("zero step period reported");

endmodule
`default_nettype wire
